// ----- rtl/pte_pkg.sv -----
// pte_pkg: shared types for the posting token encoder.
// Used by pte_front, pte_back and posting_token_encoder.
package pte_pkg;

  typedef struct packed {
    logic        err;
    logic [31:0] term_id;
    logic [31:0] doc_id;
    logic [31:0] position;
  } tok_t;

  typedef struct packed {
    logic        started;
    logic        in_order;
    logic [31:0] tokens;
    logic [31:0] last_doc;
  } entry_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_EMIT,
    ST_ERR
  } back_state_t;

  localparam logic [7:0] BYTE_MASK = 8'h7F;
  localparam logic [7:0] CONT_BIT  = 8'h80;

endpackage

// ----- rtl/posting_token_encoder.sv -----
// posting_token_encoder: top level, config registers, front and back.
// A token is queued, popped in idle, updated in calc, then sent out byte by byte.
// A token gives 1 to 10 bytes, a range error one beat; the next pop waits for idle.
// Sequential back end holds the table memory; a 2-entry queue decouples the front.
// Reset: synchronous rst_n; a clear sweep of all VOCAB_SIZE entries keeps busy high.
// The receiver cannot stall; each out_valid beat is taken that cycle.
module posting_token_encoder #(
  parameter int VOCAB_SIZE = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_term_id,
  input  logic [31:0] in_doc_id,
  input  logic [31:0] in_position,
  output logic        out_valid,
  output logic [15:0] out_chain_term,
  output logic [7:0]  out_chain_byte,
  output logic        out_last_byte,
  output logic        out_first_touch,
  output logic        out_starts_doc,
  output logic        out_out_of_order,
  output logic [31:0] out_token_total,
  output logic        out_range_error,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data
);

  logic                pos_en_r;
  logic [16:0]         vocab_r;
  logic                q_valid, q_pop;
  pte_pkg::tok_t       q_tok;
  pte_pkg::back_stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_en_r <= 1'b1;
      vocab_r  <= 17'h10000;
    end else if (cfg_we) begin
      if (cfg_index) vocab_r <= cfg_data;
      else pos_en_r <= cfg_data[0];
    end
  end

  pte_front #(.VOCAB_SIZE(VOCAB_SIZE)) u_front (
    .clk, .rst_n, .start, .busy, .in_term_id, .in_doc_id, .in_position,
    .vocab_count(vocab_r), .stat, .q_valid, .q_tok, .q_pop
  );

  pte_back #(.VOCAB_SIZE(VOCAB_SIZE)) u_back (
    .clk, .rst_n, .pos_en(pos_en_r), .q_valid, .q_tok, .q_pop, .stat,
    .out_valid, .out_chain_term, .out_chain_byte, .out_last_byte,
    .out_first_touch, .out_starts_doc, .out_out_of_order, .out_token_total,
    .out_range_error
  );

endmodule

// ----- rtl/pte_front.sv -----
// pte_front: accepts tokens, range-checks the term id, queues them.
// Depends on pte_pkg.
module pte_front #(
  parameter int VOCAB_SIZE = 65536
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [31:0]         in_term_id,
  input  logic [31:0]         in_doc_id,
  input  logic [31:0]         in_position,
  input  logic [16:0]         vocab_count,
  input  pte_pkg::back_stat_t stat,
  output logic                q_valid,
  output pte_pkg::tok_t       q_tok,
  input  logic                q_pop
);

  localparam logic [32:0] VS = 33'(VOCAB_SIZE);

  pte_pkg::tok_t q_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push, err;

  assign busy    = (cnt_r == 2'd2) || stat.clearing;
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_tok   = q_r[rp_r];

  always_comb begin
    if ({16'b0, vocab_count} > VS) begin
      err = {1'b0, in_term_id} >= VS;
    end else begin
      err = in_term_id >= {15'b0, vocab_count};
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !q_pop) cnt_nxt = cnt_r + 2'd1;
    else if (!push && q_pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= '{err: err, term_id: in_term_id, doc_id: in_doc_id,
                     position: in_position};
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (q_pop) rp_r <= !rp_r;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/pte_back.sv -----
// pte_back: per-term table, update and byte-serial varint emission.
// Depends on pte_pkg.
module pte_back #(
  parameter int VOCAB_SIZE = 65536
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                pos_en,
  input  logic                q_valid,
  input  pte_pkg::tok_t       q_tok,
  output logic                q_pop,
  output pte_pkg::back_stat_t stat,
  output logic                out_valid,
  output logic [15:0]         out_chain_term,
  output logic [7:0]          out_chain_byte,
  output logic                out_last_byte,
  output logic                out_first_touch,
  output logic                out_starts_doc,
  output logic                out_out_of_order,
  output logic [31:0]         out_token_total,
  output logic                out_range_error
);

  localparam int AW = (VOCAB_SIZE > 1) ? $clog2(VOCAB_SIZE) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(VOCAB_SIZE - 1);

  pte_pkg::entry_t      mem [VOCAB_SIZE];
  pte_pkg::entry_t      rd_r, wr_d;
  pte_pkg::tok_t        tok_r;
  pte_pkg::back_state_t st_r, st_nxt;
  logic [AW-1:0]        clr_r;
  logic [33:0]          sh_r, sh_nxt;
  logic [32:0]          zz_r;
  logic                 newdoc_r, first_r, ooo_r, phase_r;
  logic [31:0]          tot_r;
  logic                 first_c, newdoc_c, back_c, inord_c, seg_last;
  logic [31:0]          base_c, tot_c;
  logic [32:0]          zz_c;
  logic                 mem_we;
  logic [AW-1:0]        mem_wa;

  always_comb begin
    first_c  = !rd_r.started;
    newdoc_c = first_c || (rd_r.last_doc != tok_r.doc_id);
    base_c   = first_c ? 32'd0 : rd_r.last_doc;
    back_c   = tok_r.doc_id < base_c;
    zz_c     = back_c ? {base_c - tok_r.doc_id, 1'b0} - 33'd1
                      : {tok_r.doc_id - base_c, 1'b0};
    inord_c  = rd_r.in_order && !back_c;
    tot_c    = (&rd_r.tokens) ? rd_r.tokens : rd_r.tokens + 32'd1;
    seg_last = (sh_r[33:7] == 27'd0);
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      pte_pkg::ST_CLEAR: if (clr_r == LAST_IDX) st_nxt = pte_pkg::ST_IDLE;
      pte_pkg::ST_IDLE:  if (q_valid) st_nxt = q_tok.err ? pte_pkg::ST_ERR : pte_pkg::ST_CALC;
      pte_pkg::ST_CALC:  st_nxt = pte_pkg::ST_EMIT;
      pte_pkg::ST_EMIT:  if (seg_last && (phase_r || !newdoc_r)) st_nxt = pte_pkg::ST_IDLE;
      pte_pkg::ST_ERR:   st_nxt = pte_pkg::ST_IDLE;
      default:           st_nxt = pte_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop         = 1'b0;
    stat.clearing = 1'b0;
    mem_we        = 1'b0;
    mem_wa        = tok_r.term_id[AW-1:0];
    wr_d          = rd_r;
    out_valid     = 1'b0;
    case (st_r)
      pte_pkg::ST_CLEAR: begin
        stat.clearing = 1'b1;
        mem_we        = 1'b1;
        mem_wa        = clr_r;
        wr_d          = '{started: 1'b0, in_order: 1'b1, tokens: 32'd0, last_doc: 32'd0};
      end
      pte_pkg::ST_IDLE: q_pop = q_valid;
      pte_pkg::ST_CALC: begin
        mem_we        = 1'b1;
        wr_d.started  = 1'b1;
        wr_d.in_order = inord_c;
        wr_d.tokens   = tot_c;
        if (newdoc_c) wr_d.last_doc = tok_r.doc_id;
      end
      pte_pkg::ST_EMIT, pte_pkg::ST_ERR: out_valid = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    if (st_r == pte_pkg::ST_ERR) begin
      out_chain_term   = 16'd0;
      out_chain_byte   = 8'd0;
      out_last_byte    = 1'b1;
      out_first_touch  = 1'b0;
      out_starts_doc   = 1'b0;
      out_out_of_order = 1'b0;
      out_token_total  = 32'd0;
      out_range_error  = 1'b1;
    end else begin
      out_chain_term   = tok_r.term_id[15:0];
      out_chain_byte   = (sh_r[7:0] & pte_pkg::BYTE_MASK)
                         | (seg_last ? 8'd0 : pte_pkg::CONT_BIT);
      out_last_byte    = seg_last && (phase_r || !newdoc_r);
      out_first_touch  = first_r;
      out_starts_doc   = newdoc_r;
      out_out_of_order = ooo_r;
      out_token_total  = tot_r;
      out_range_error  = 1'b0;
    end
  end

  always_comb begin
    sh_nxt = sh_r;
    if (st_r == pte_pkg::ST_CALC) begin
      sh_nxt = pos_en ? {1'b0, tok_r.position, newdoc_c} : {33'd0, newdoc_c};
    end else if (st_r == pte_pkg::ST_EMIT) begin
      sh_nxt = seg_last ? {1'b0, zz_r} : {7'd0, sh_r[33:7]};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= wr_d;
    if (st_r == pte_pkg::ST_IDLE && q_valid) begin
      rd_r  <= mem[q_tok.term_id[AW-1:0]];
      tok_r <= q_tok;
    end
    sh_r <= sh_nxt;
    if (st_r == pte_pkg::ST_CALC) begin
      zz_r     <= zz_c;
      newdoc_r <= newdoc_c;
      first_r  <= first_c;
      ooo_r    <= !inord_c;
      tot_r    <= tot_c;
    end
    if (!rst_n) begin
      st_r    <= pte_pkg::ST_CLEAR;
      clr_r   <= '0;
      phase_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == pte_pkg::ST_CLEAR) clr_r <= clr_r + AW'(1);
      if (st_r == pte_pkg::ST_CALC) phase_r <= 1'b0;
      else if (st_r == pte_pkg::ST_EMIT && seg_last) phase_r <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_no_out_clear: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clearing |-> !out_valid) else $error("beat during clear");
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_range_error) |=> !out_valid) else $error("error beat repeated");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (st_r == pte_pkg::ST_IDLE && q_valid)) else $error("pop outside idle");
  a_calc_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == pte_pkg::ST_CALC) |=> (out_valid && !out_range_error))
    else $error("no byte after calc");
`endif

endmodule

// ----- test/tb_top.sv -----
// tb_top: self-checking testbench for posting_token_encoder.
// Drives a directed table, then random tokens; a behavioral table model
// predicts every chain byte. Depends on rtl/pte_pkg.sv and the block's RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VOCAB = 65536;
  localparam logic CFG_POS_EN = 1'b0;
  localparam logic CFG_VOCAB  = 1'b1;

  typedef struct packed {
    logic [15:0] term;
    logic [7:0]  byte_val;
    logic        last;
    logic        first;
    logic        new_doc;
    logic        ooo;
    logic [31:0] total;
    logic        rerr;
  } chain_beat_t;

  typedef struct {
    logic [31:0] tid;
    logic [31:0] doc;
    logic [31:0] pos;
    logic        chk;
    logic [7:0]  byte0;
    logic        err;
  } dir_row_t;

  logic clk, rst_n, start, busy, out_valid, cfg_we, cfg_index;
  logic [31:0] in_term_id, in_doc_id, in_position;
  logic [15:0] out_chain_term;
  logic [7:0]  out_chain_byte;
  logic out_last_byte, out_first_touch, out_starts_doc, out_out_of_order, out_range_error;
  logic [31:0] out_token_total;
  logic [16:0] cfg_data;

  posting_token_encoder dut (.*);

  bit          started_q [VOCAB];
  bit          in_order_q [VOCAB];
  logic [31:0] last_doc_q [VOCAB];
  logic [31:0] tokens_q [VOCAB];
  bit          pos_en;
  logic [16:0] vocab_lim;
  chain_beat_t beats_pending [$];
  int errors, n_tokens, n_beats, n_rerr;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic void push_leb(input logic [63:0] v, ref logic [7:0] q[$]);
    do begin
      q.insert(q.size(), {(v >> 7) != 0, v[6:0]});
      v = v >> 7;
    end while (v != 0);
  endfunction

  function automatic void predict_token(input logic [31:0] tid, doc, pos);
    logic [7:0] bytes [$];
    logic [63:0] tag, zz;
    logic [31:0] base;
    logic [16:0] lim;
    bit first, nd;
    chain_beat_t b;
    lim = (vocab_lim > VOCAB) ? 17'(VOCAB) : vocab_lim;
    if ({1'b0, tid} >= {16'd0, lim}) begin
      b = '0;
      b.last = 1;
      b.rerr = 1;
      beats_pending.insert(beats_pending.size(), b);
      return;
    end
    first = !started_q[tid];
    nd = first || last_doc_q[tid] != doc;
    tag = {63'd0, nd};
    if (pos_en) tag |= {31'd0, pos, 1'b0};
    push_leb(tag, bytes);
    if (nd) begin
      base = first ? 32'd0 : last_doc_q[tid];
      if (doc >= base) zz = {31'd0, doc - base, 1'b0};
      else begin
        zz = {31'd0, base - doc, 1'b0} - 64'd1;
        if (!first) in_order_q[tid] = 0;
      end
      push_leb(zz, bytes);
      last_doc_q[tid] = doc;
      started_q[tid] = 1;
    end
    if (tokens_q[tid] != 32'hFFFF_FFFF) tokens_q[tid]++;
    foreach (bytes[k]) begin
      b.term = tid[15:0];
      b.byte_val = bytes[k];
      b.last = (k == bytes.size() - 1);
      b.first = first;
      b.new_doc = nd;
      b.ooo = !in_order_q[tid];
      b.total = tokens_q[tid];
      b.rerr = 0;
      beats_pending.insert(beats_pending.size(), b);
    end
  endfunction

  always @(posedge clk) begin
    chain_beat_t got, want;
    if (rst_n && out_valid) begin
      got = {out_chain_term, out_chain_byte, out_last_byte, out_first_touch,
             out_starts_doc, out_out_of_order, out_token_total, out_range_error};
      n_beats++;
      if (beats_pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat %h", $realtime, got);
      end else begin
        want = beats_pending.pop_front();
        if (got.rerr) n_rerr++;
        if (got.term != want.term)
          $display("%0t: chain_term exp %h got %h", $realtime, want.term, got.term);
        if (got.byte_val != want.byte_val)
          $display("%0t: chain_byte exp %h got %h", $realtime, want.byte_val, got.byte_val);
        if (got.last != want.last)
          $display("%0t: last_byte exp %b got %b", $realtime, want.last, got.last);
        if (got.first != want.first)
          $display("%0t: first_touch exp %b got %b", $realtime, want.first, got.first);
        if (got.new_doc != want.new_doc)
          $display("%0t: starts_doc exp %b got %b", $realtime, want.new_doc, got.new_doc);
        if (got.ooo != want.ooo)
          $display("%0t: out_of_order exp %b got %b", $realtime, want.ooo, got.ooo);
        if (got.total != want.total)
          $display("%0t: token_total exp %h got %h", $realtime, want.total, got.total);
        if (got.rerr != want.rerr)
          $display("%0t: range_error exp %b got %b", $realtime, want.rerr, got.rerr);
        if (got !== want) errors++;
      end
    end
  end

  task automatic send_token(input logic [31:0] tid, doc, pos);
    int idle;
    idle = $urandom_range(0, 6);
    if (idle != 0) begin
      start <= 0;
      repeat (idle) @(posedge clk);
    end
    start <= 1;
    in_term_id <= tid;
    in_doc_id <= doc;
    in_position <= pos;
    do @(posedge clk); while (busy);
    predict_token(tid, doc, pos);
    n_tokens++;
  endtask

  task automatic write_cfg(input logic idx, input logic [16:0] val);
    int guard;
    guard = 0;
    start <= 0;
    while (beats_pending.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (16) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == CFG_POS_EN) pos_en = val[0];
    else vocab_lim = val;
  endtask

  task automatic random_phase(input int count, input logic [15:0] tmask, input int tlim);
    logic [31:0] tid, doc, pos;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0: tid = $urandom();
        1: tid = 32'(tlim + $urandom_range(0, 3));
        default: tid = $urandom() & tmask;
      endcase
      case ($urandom_range(0, 5))
        0: doc = $urandom();
        1: doc = started_q[tid[15:0]] ? last_doc_q[tid[15:0]] - 1 : $urandom_range(0, 5);
        2, 3: doc = started_q[tid[15:0]] ? last_doc_q[tid[15:0]] : 0;
        default: doc = (started_q[tid[15:0]] ? last_doc_q[tid[15:0]] : 0)
                       + $urandom_range(1, 300);
      endcase
      pos = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 2000);
      send_token(tid, doc, pos);
    end
  endtask

  dir_row_t dir_rows [] = '{
    '{32'd0, 32'd0, 32'd0, 1'b1, 8'h01, 1'b0},
    '{32'd0, 32'd0, 32'd5, 1'b1, 8'h0A, 1'b0},
    '{32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'hFF, 1'b0},
    '{32'd0, 32'd0, 32'd1, 1'b0, 8'h00, 1'b0},
    '{32'd0, 32'd7, 32'd63, 1'b1, 8'h7F, 1'b0},
    '{32'd65535, 32'hFFFF_FFFF, 32'd0, 1'b1, 8'h01, 1'b0},
    '{32'd65535, 32'd0, 32'd64, 1'b1, 8'h81, 1'b0},
    '{32'd65536, 32'd1, 32'd1, 1'b1, 8'h00, 1'b1},
    '{32'hFFFF_FFFF, 32'd1, 32'd1, 1'b1, 8'h00, 1'b1},
    '{32'd3, 32'h8000_0000, 32'h8000_0000, 1'b0, 8'h00, 1'b0},
    '{32'd3, 32'd0, 32'd2, 1'b0, 8'h00, 1'b0},
    '{32'd3, 32'd0, 32'd3, 1'b0, 8'h00, 1'b0}
  };

  initial begin
    dir_row_t r;
    chain_beat_t head;
    int guard;
    for (int i = 0; i < VOCAB; i++) begin
      started_q[i] = 0;
      in_order_q[i] = 1;
      last_doc_q[i] = 0;
      tokens_q[i] = 0;
    end
    pos_en = 1;
    vocab_lim = 17'd65536;
    errors = 0;
    rst_n <= 0;
    start <= 0;
    cfg_we <= 0;
    cfg_index <= CFG_POS_EN;
    cfg_data <= '0;
    in_term_id <= '0;
    in_doc_id <= '0;
    in_position <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      send_token(r.tid, r.doc, r.pos);
      if (r.chk) begin
        head = '0;
        // first byte of the token's chain sits after any earlier pending beats
        for (int j = beats_pending.size() - 1; j >= 0; j--)
          if (j == 0 || beats_pending[j - 1].last) begin
            head = beats_pending[j];
            break;
          end
        if (head.byte_val != r.byte0 || head.rerr != r.err) begin
          errors++;
          $display("%0t: table row %0d exp byte %h err %b, model %h %b",
                   $realtime, i, r.byte0, r.err, head.byte_val, head.rerr);
        end
      end
    end

    // positions off, tiny, oversized and zero vocabularies
    write_cfg(CFG_POS_EN, 17'd0);
    send_token(32'd1, 32'd4, 32'd9);
    send_token(32'd1, 32'd2, 32'd9);
    write_cfg(CFG_VOCAB, 17'd1);
    send_token(32'd1, 32'd2, 32'd0);
    send_token(32'd0, 32'd9, 32'd0);
    write_cfg(CFG_VOCAB, 17'h1FFFF);
    send_token(32'd65535, 32'd1, 32'd0);
    write_cfg(CFG_VOCAB, 17'd0);
    send_token(32'd0, 32'd1, 32'd0);

    write_cfg(CFG_POS_EN, 17'd1);
    write_cfg(CFG_VOCAB, 17'd65536);
    random_phase(100, 16'h000F, 65536);
    write_cfg(CFG_POS_EN, 17'd0);
    write_cfg(CFG_VOCAB, 17'd40);
    random_phase(60, 16'h003F, 40);
    write_cfg(CFG_POS_EN, 17'd1);
    write_cfg(CFG_VOCAB, 17'd2);
    random_phase(40, 16'h0003, 2);
    write_cfg(CFG_VOCAB, 17'd65536);
    random_phase(60, 16'hFFFF, 65536);

    start <= 0;
    guard = 0;
    while (beats_pending.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    $display("Covered %0d tokens, %0d chain beats, %0d range errors checked.",
             n_tokens, n_beats, n_rerr);
    if (errors == 0 && beats_pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d beats still expected", errors, beats_pending.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
